/* hdl/spg_pkg.sv */
// Shared constants, codes and types of the slotted page store.
package spg_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_SLOTS  = 2048;
    localparam int HDR_BYTES  = 4;
    localparam int SLOT_BYTES = 2;

    localparam int PAGE_AW = $clog2(PAGE_BYTES);   // page byte address
    localparam int OFF_W   = PAGE_AW + 1;          // offsets up to PAGE_BYTES
    localparam int SLOT_AW = $clog2(MAX_SLOTS);    // slot directory address
    localparam int CNT_W   = SLOT_AW + 1;          // slot count up to MAX_SLOTS
    localparam int NEED_W  = OFF_W + 2;            // space check sum

    // Field widths of the request and result items
    localparam int FUNC_W  = 2;
    localparam int SIDX_W  = 11;
    localparam int BIDX_W  = 12;
    localparam int TSIZE_W = 13;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_SLOT  = 2'd2,
        ST_OUT_RANGE = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // latch request, read slot directory
        logic exec;     // update page state, access page bytes
        logic load;     // load the result register
    } spg_cmd_t;

endpackage

/* hdl/spg_ctrl.sv */
// Sequencing state machine of the slotted page store.
module spg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output spg_pkg::spg_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* hdl/spg_datapath.sv */
// Page state, slot directory and page byte memories, result register.
module spg_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  spg_pkg::spg_cmd_t              cmd,
    input  logic [spg_pkg::FUNC_W-1:0]     in_func,
    input  logic [spg_pkg::SIDX_W-1:0]     in_slot_index,
    input  logic [spg_pkg::BIDX_W-1:0]     in_byte_index,
    input  logic [spg_pkg::TSIZE_W-1:0]    in_tuple_size,
    input  logic [spg_pkg::BYTE_W-1:0]     in_data_byte,
    output logic [spg_pkg::M_DATA_W-1:0]   res_data
);

    // Memories
    logic [spg_pkg::BYTE_W-1:0] page_mem [spg_pkg::PAGE_BYTES];
    logic [spg_pkg::OFF_W-1:0]  slot_mem [spg_pkg::MAX_SLOTS];

    // Latched request
    spg_pkg::func_t               func_reg;
    logic [spg_pkg::SIDX_W-1:0]   sidx_reg;
    logic [spg_pkg::BIDX_W-1:0]   bidx_reg;
    logic [spg_pkg::TSIZE_W-1:0]  tsize_reg;
    logic [spg_pkg::BYTE_W-1:0]   dbyte_reg;
    logic [spg_pkg::OFF_W-1:0]    off_rd_reg;
    logic [spg_pkg::OFF_W-1:0]    prev_rd_reg;
    logic [spg_pkg::BYTE_W-1:0]   page_rd_reg;

    // Page state
    logic [spg_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [spg_pkg::OFF_W-1:0]    free_reg, free_next;
    logic [spg_pkg::OFF_W-1:0]    base_reg, base_next;
    logic [spg_pkg::OFF_W-1:0]    end_reg, end_next;      // end of tuple being filled
    logic                         accepted_reg, accepted_next;

    // Pending result
    spg_pkg::status_t             res_status_reg, res_status_next;
    logic [spg_pkg::SIDX_W-1:0]   res_slot_reg, res_slot_next;
    logic [spg_pkg::TSIZE_W-1:0]  res_size_reg, res_size_next;
    logic                         res_byte_en_reg, res_byte_en_next;
    logic [spg_pkg::M_DATA_W-1:0] out_data_reg;

    // Execute-step logic
    logic [spg_pkg::NEED_W-1:0]   need;
    logic                         start_ok;
    logic [spg_pkg::OFF_W-1:0]    new_free;
    logic [spg_pkg::OFF_W:0]      ins_addr;
    logic [spg_pkg::OFF_W-1:0]    rd_end;
    logic [spg_pkg::OFF_W-1:0]    rd_size;
    logic [spg_pkg::OFF_W:0]      rd_addr;
    logic                         slot_ok;
    logic [spg_pkg::PAGE_AW-1:0]  page_addr;
    logic                         page_we;
    logic                         slot_we;
    logic [spg_pkg::SLOT_AW-1:0]  cur_slot;
    logic [spg_pkg::BYTE_W-1:0]   out_byte;

    assign cur_slot = spg_pkg::SLOT_AW'(count_reg - spg_pkg::CNT_W'(1));

    assign need = spg_pkg::NEED_W'(spg_pkg::HDR_BYTES)
                + spg_pkg::NEED_W'(spg_pkg::SLOT_BYTES)
                  * (spg_pkg::NEED_W'(count_reg) + spg_pkg::NEED_W'(1))
                + spg_pkg::NEED_W'(tsize_reg);
    assign start_ok = (tsize_reg != '0)
                   && (count_reg < spg_pkg::CNT_W'(spg_pkg::MAX_SLOTS))
                   && (spg_pkg::NEED_W'(free_reg) >= need);
    assign new_free = free_reg - spg_pkg::OFF_W'(tsize_reg);
    assign ins_addr = (spg_pkg::OFF_W+1)'(base_reg) + (spg_pkg::OFF_W+1)'(bidx_reg);

    // Slot zero ends at the page end, others at the previous slot's offset
    assign rd_end  = (sidx_reg == '0) ? spg_pkg::OFF_W'(spg_pkg::PAGE_BYTES) : prev_rd_reg;
    assign rd_size = (rd_end >= off_rd_reg) ? rd_end - off_rd_reg : '0;
    assign rd_addr = (spg_pkg::OFF_W+1)'(off_rd_reg) + (spg_pkg::OFF_W+1)'(bidx_reg);
    assign slot_ok = (spg_pkg::CNT_W'(sidx_reg) < count_reg);

    always_comb begin
        count_next       = count_reg;
        free_next        = free_reg;
        base_next        = base_reg;
        end_next         = end_reg;
        accepted_next    = accepted_reg;
        res_status_next  = spg_pkg::ST_OK;
        res_slot_next    = '0;
        res_size_next    = '0;
        res_byte_en_next = 1'b0;
        page_addr        = rd_addr[spg_pkg::PAGE_AW-1:0];
        page_we          = 1'b0;
        slot_we          = 1'b0;
        case (func_reg)
            spg_pkg::FUNC_CLEAR: begin
                count_next    = '0;
                free_next     = spg_pkg::OFF_W'(spg_pkg::PAGE_BYTES);
                accepted_next = 1'b0;
            end
            spg_pkg::FUNC_INSERT: begin
                if (bidx_reg == '0) begin
                    page_addr = new_free[spg_pkg::PAGE_AW-1:0];
                    if (start_ok) begin
                        free_next     = new_free;
                        base_next     = new_free;
                        end_next      = free_reg;
                        count_next    = count_reg + spg_pkg::CNT_W'(1);
                        accepted_next = 1'b1;
                        res_slot_next = count_reg[spg_pkg::SLOT_AW-1:0];
                        page_we       = 1'b1;
                        slot_we       = 1'b1;
                    end else begin
                        accepted_next   = 1'b0;
                        res_status_next = spg_pkg::ST_NO_SPACE;
                    end
                end else if (!accepted_reg || count_reg == '0) begin
                    res_status_next = spg_pkg::ST_NO_SPACE;
                end else begin
                    page_addr     = ins_addr[spg_pkg::PAGE_AW-1:0];
                    res_slot_next = cur_slot;
                    if (ins_addr >= (spg_pkg::OFF_W+1)'(end_reg)) begin
                        res_status_next = spg_pkg::ST_OUT_RANGE;
                    end else begin
                        page_we = 1'b1;
                    end
                end
            end
            spg_pkg::FUNC_READ: begin
                res_slot_next = sidx_reg;
                if (!slot_ok) begin
                    res_status_next = spg_pkg::ST_BAD_SLOT;
                end else begin
                    res_size_next = spg_pkg::TSIZE_W'(rd_size);
                    if (spg_pkg::OFF_W'(bidx_reg) >= rd_size) begin
                        res_status_next = spg_pkg::ST_OUT_RANGE;
                    end else begin
                        res_byte_en_next = 1'b1;
                    end
                end
            end
            default: begin
                // unused code: no operation
            end
        endcase
    end

    // Request latch and slot directory reads
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg    <= spg_pkg::func_t'(in_func);
            sidx_reg    <= in_slot_index;
            bidx_reg    <= in_byte_index;
            tsize_reg   <= in_tuple_size;
            dbyte_reg   <= in_data_byte;
            off_rd_reg  <= slot_mem[in_slot_index];
            prev_rd_reg <= slot_mem[in_slot_index - spg_pkg::SLOT_AW'(1)];
        end
        if (cmd.exec && slot_we) begin
            slot_mem[count_reg[spg_pkg::SLOT_AW-1:0]] <= new_free;
        end
    end

    // Page byte memory, single port
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (page_we) begin
                page_mem[page_addr] <= dbyte_reg;
            end
            page_rd_reg <= page_mem[page_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            free_reg     <= spg_pkg::OFF_W'(spg_pkg::PAGE_BYTES);
            base_reg     <= '0;
            end_reg      <= '0;
            accepted_reg <= 1'b0;
        end else if (cmd.exec) begin
            count_reg    <= count_next;
            free_reg     <= free_next;
            base_reg     <= base_next;
            end_reg      <= end_next;
            accepted_reg <= accepted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg  <= res_status_next;
            res_slot_reg    <= res_slot_next;
            res_size_reg    <= res_size_next;
            res_byte_en_reg <= res_byte_en_next;
        end
    end

    assign out_byte = res_byte_en_reg ? page_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_data_reg <= {5'd0, free_reg, count_reg, out_byte,
                             res_size_reg, res_slot_reg, res_status_reg};
        end
    end

    assign res_data = out_data_reg;

endmodule

/* hdl/slotted_page_store.sv */
// Top level of the slotted page store: controller and datapath.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata: func, slot_index, byte_index, tuple_size, data_byte
//  m_      | out | m_tvalid/m_tready | m_tdata: status, slot_out, size_out, byte_out,
//          |     |                   |          slot_total, free_boundary
//
// Each request passes through three steps: accept with slot directory read, execute with the
// page byte access, then load of the result register; the single-port page memory read
// follows the directory read, so the two take separate steps. Reset clears page and handshake
// state only; both memories keep stale data. Stale directory entries are never read through a
// valid slot, but unwritten tuple bytes are. A stalled result holds in the result register
// while the next request is still accepted; it waits in its last step until the register frees.
module slotted_page_store (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [1:0] func, [12:2] slot_index, [24:13] byte_index, [37:25] tuple_size,
    // [45:38] data_byte, [47:46] zero
    input  logic [spg_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [1:0] status, [12:2] slot_out, [25:13] size_out, [33:26] byte_out,
    // [45:34] slot_total, [58:46] free_boundary, [63:59] zero
    output logic [spg_pkg::M_DATA_W-1:0] m_tdata
);

    spg_pkg::spg_cmd_t cmd;

    spg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    spg_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_func       (s_tdata[1:0]),
        .in_slot_index (s_tdata[12:2]),
        .in_byte_index (s_tdata[24:13]),
        .in_tuple_size (s_tdata[37:25]),
        .in_data_byte  (s_tdata[45:38]),
        .res_data      (m_tdata)
    );

endmodule

/* hdl/spg_checker.sv */
// Port-level checks of the slotted page store, bound to the top level.
module spg_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [spg_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [spg_pkg::M_DATA_W-1:0] m_tdata
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // Failed inserts and bad slots carry no size and no byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == spg_pkg::ST_NO_SPACE || m_tdata[1:0] == spg_pkg::ST_BAD_SLOT)
        |-> m_tdata[33:13] == '0)
        else $error("size or byte given with a failure status");

    // Header and slot directory always fit below the free boundary
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> {2'b00, m_tdata[58:46]}
                     >= 15'(spg_pkg::HDR_BYTES) + 15'(spg_pkg::SLOT_BYTES) * {3'b000, m_tdata[45:34]})
        else $error("free boundary overlaps slot directory");

endmodule

bind slotted_page_store spg_checker u_spg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/spg_checker.sv */
// Scoreboard for the slotted page store: predicts each request's result and checks it.
module spg_scoreboard (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [spg_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [spg_pkg::M_DATA_W-1:0] m_tdata,
    output int                           fail_count,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Result fields, status in the low bits as on m_tdata
    typedef struct packed {
        logic [spg_pkg::OFF_W-1:0]   boundary;
        logic [spg_pkg::CNT_W-1:0]   total;
        logic [spg_pkg::BYTE_W-1:0]  data;
        logic [spg_pkg::TSIZE_W-1:0] size;
        logic [spg_pkg::SIDX_W-1:0]  slot;
        spg_pkg::status_t            status;
    } page_result_t;

    logic [spg_pkg::BYTE_W-1:0] page_mem [spg_pkg::PAGE_BYTES];
    logic [spg_pkg::OFF_W-1:0]  slot_off [spg_pkg::MAX_SLOTS];
    logic [spg_pkg::CNT_W-1:0]  used_slots;
    logic [spg_pkg::OFF_W-1:0]  free_off;
    logic [spg_pkg::OFF_W-1:0]  fill_base;
    logic                       fill_open;

    page_result_t result_q [$];

    // Tuple of slot s ends where the previous slot's tuple starts
    function automatic int slot_end(input int s);
        return (s == 0) ? spg_pkg::PAGE_BYTES : int'(slot_off[s-1]);
    endfunction

    function automatic page_result_t apply_request(input logic [spg_pkg::S_DATA_W-1:0] req);
        logic [spg_pkg::FUNC_W-1:0]  fn;
        logic [spg_pkg::SIDX_W-1:0]  sidx;
        logic [spg_pkg::BIDX_W-1:0]  bidx;
        logic [spg_pkg::TSIZE_W-1:0] tsize;
        logic [spg_pkg::BYTE_W-1:0]  dbyte;
        page_result_t                r;
        int                          cnt;
        int                          addr;
        int                          off;
        int                          len;
        fn    = req[1:0];
        sidx  = req[12:2];
        bidx  = req[24:13];
        tsize = req[37:25];
        dbyte = req[45:38];
        cnt   = used_slots;
        r        = '0;
        r.status = spg_pkg::ST_OK;
        case (fn)
            spg_pkg::FUNC_CLEAR: begin
                used_slots = '0;
                free_off   = spg_pkg::OFF_W'(spg_pkg::PAGE_BYTES);
                fill_open  = 1'b0;
            end
            spg_pkg::FUNC_INSERT: begin
                if (bidx == '0) begin
                    if (tsize == '0 || cnt >= spg_pkg::MAX_SLOTS ||
                        int'(free_off) < spg_pkg::HDR_BYTES
                                         + spg_pkg::SLOT_BYTES * (cnt + 1) + int'(tsize)) begin
                        r.status  = spg_pkg::ST_NO_SPACE;
                        fill_open = 1'b0;
                    end else begin
                        free_off      = free_off - tsize;
                        slot_off[cnt] = free_off;
                        fill_base     = free_off;
                        r.slot        = spg_pkg::SIDX_W'(cnt);
                        used_slots    = used_slots + spg_pkg::CNT_W'(1);
                        fill_open     = 1'b1;
                        page_mem[int'(free_off) % spg_pkg::PAGE_BYTES] = dbyte;
                    end
                end else if (!fill_open || cnt == 0) begin
                    r.status = spg_pkg::ST_NO_SPACE;
                end else begin
                    r.slot = spg_pkg::SIDX_W'(cnt - 1);
                    addr   = int'(fill_base) + int'(bidx);
                    if (addr >= slot_end(cnt - 1))
                        r.status = spg_pkg::ST_OUT_RANGE;
                    else
                        page_mem[addr % spg_pkg::PAGE_BYTES] = dbyte;
                end
            end
            spg_pkg::FUNC_READ: begin
                r.slot = sidx;
                if (int'(sidx) >= cnt) begin
                    r.status = spg_pkg::ST_BAD_SLOT;
                end else begin
                    off    = slot_off[sidx];
                    len    = (slot_end(sidx) >= off) ? slot_end(sidx) - off : 0;
                    r.size = spg_pkg::TSIZE_W'(len);
                    if (int'(bidx) >= len)
                        r.status = spg_pkg::ST_OUT_RANGE;
                    else
                        r.data = page_mem[(off + int'(bidx)) % spg_pkg::PAGE_BYTES];
                end
            end
            default: ;  // unused code: no-op
        endcase
        r.total    = used_slots;
        r.boundary = free_off;
        return r;
    endfunction

    always @(posedge aclk) begin
        page_result_t exp_r;
        page_result_t got_r;
        if (!aresetn) begin
            used_slots = '0;
            free_off   = spg_pkg::OFF_W'(spg_pkg::PAGE_BYTES);
            fill_base  = '0;
            fill_open  = 1'b0;
            result_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                result_q.push_back(apply_request(s_tdata));
            if (m_tvalid && m_tready) begin
                got_r = m_tdata[$bits(page_result_t)-1:0];
                if (result_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result with no request outstanding: st=%0d slot=%0d",
                                 $realtime, got_r.status, got_r.slot);
                    fail_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (got_r.status !== exp_r.status || got_r.slot !== exp_r.slot ||
                        got_r.size !== exp_r.size || got_r.data !== exp_r.data ||
                        got_r.total !== exp_r.total || got_r.boundary !== exp_r.boundary) begin
                        if (fail_count < 10) begin
                            $display("%0t: exp st=%0d sl=%0d sz=%0d b=%02h tot=%0d free=%0d",
                                     $realtime, exp_r.status, exp_r.slot, exp_r.size,
                                     exp_r.data, exp_r.total, exp_r.boundary);
                            $display("%0t: got st=%0d sl=%0d sz=%0d b=%02h tot=%0d free=%0d",
                                     $realtime, got_r.status, got_r.slot, got_r.size,
                                     got_r.data, got_r.total, got_r.boundary);
                        end
                        fail_count++;
                    end
                end
            end
        end
        pending = result_q.size();
    end

endmodule

/* bench/tb.sv */
// Testbench top for the slotted page store: clock, reset, request stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [spg_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int REQ_TARGET  = 1350;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [spg_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [spg_pkg::M_DATA_W-1:0] m_tdata;
    int                           fail_count;
    int                           pending;

    // Page layout as seen by the stimulus, so reads only touch written bytes
    int tuples_held = 0;
    int room_left   = spg_pkg::PAGE_BYTES;
    int fill_base   = 0;
    bit fill_open   = 0;
    int tuple_off [spg_pkg::MAX_SLOTS];
    bit byte_set  [spg_pkg::PAGE_BYTES];

    int sent       = 0;
    int burst_left = 0;
    int quiet      = 0;

    slotted_page_store u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    spg_scoreboard u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int tuple_len(input int s);
        return ((s == 0) ? spg_pkg::PAGE_BYTES : tuple_off[s-1]) - tuple_off[s];
    endfunction

    task automatic send_item(input int fn, input int sidx, input int bidx, input int tsize,
                             input int dbyte);
        logic [spg_pkg::FUNC_W-1:0]  fn_v;
        logic [spg_pkg::SIDX_W-1:0]  sidx_v;
        logic [spg_pkg::BIDX_W-1:0]  bidx_v;
        logic [spg_pkg::TSIZE_W-1:0] tsize_v;
        logic [spg_pkg::BYTE_W-1:0]  dbyte_v;
        int tail;
        fn_v    = spg_pkg::FUNC_W'(fn);
        sidx_v  = spg_pkg::SIDX_W'(sidx);
        bidx_v  = spg_pkg::BIDX_W'(bidx);
        tsize_v = spg_pkg::TSIZE_W'(tsize);
        dbyte_v = spg_pkg::BYTE_W'(dbyte);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom % 4 == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, dbyte_v, tsize_v, bidx_v, sidx_v, fn_v};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        sent++;
        case (fn_v)
            spg_pkg::FUNC_CLEAR: begin
                tuples_held = 0;
                room_left   = spg_pkg::PAGE_BYTES;
                fill_open   = 0;
            end
            spg_pkg::FUNC_INSERT: begin
                if (bidx_v == '0) begin
                    if (tsize_v != '0 && tuples_held < spg_pkg::MAX_SLOTS &&
                        room_left >= spg_pkg::HDR_BYTES
                                     + spg_pkg::SLOT_BYTES * (tuples_held + 1)
                                     + int'(tsize_v)) begin
                        room_left              = room_left - int'(tsize_v);
                        tuple_off[tuples_held] = room_left;
                        fill_base              = room_left;
                        tuples_held++;
                        fill_open              = 1;
                        byte_set[room_left]    = 1;
                    end else begin
                        fill_open = 0;
                    end
                end else if (fill_open) begin
                    tail = (tuples_held == 1) ? spg_pkg::PAGE_BYTES
                                              : tuple_off[tuples_held-2];
                    if (fill_base + int'(bidx_v) < tail)
                        byte_set[fill_base + int'(bidx_v)] = 1;
                end
            end
            default: ;
        endcase
    endtask

    // Start a tuple and fill it in order; big ones and a few small ones are abandoned
    task automatic insert_run();
        int n;
        int k;
        int i;
        int pick;
        pick = $urandom % 20;
        if (pick < 14)
            n = $urandom_range(1, 16);
        else if (pick < 17)
            n = $urandom_range(17, 64);
        else if (pick < 19)
            n = $urandom_range(100, 1200);
        else
            n = $urandom_range(1201, spg_pkg::PAGE_BYTES - 1);
        send_item(spg_pkg::FUNC_INSERT, $urandom, 0, n, $urandom);
        k = (n <= 64) ? n - 1 : $urandom_range(4, 30);
        for (i = 1; i <= k; i++) begin
            if ($urandom % 40 == 0)
                break;
            if ($urandom % 15 == 0)
                send_item(spg_pkg::FUNC_INSERT, $urandom,
                          $urandom_range(n, spg_pkg::PAGE_BYTES - 1), $urandom, $urandom);
            send_item(spg_pkg::FUNC_INSERT, $urandom, i, $urandom, $urandom);
        end
    endtask

    task automatic read_run();
        int n;
        int s;
        int b;
        int len;
        n = $urandom_range(1, 6);
        repeat (n) begin
            if (tuples_held > 0 && $urandom % 8 != 0)
                s = $urandom_range(0, tuples_held - 1);
            else
                s = $urandom_range(tuples_held, spg_pkg::MAX_SLOTS - 1);
            if (s < tuples_held) begin
                len = tuple_len(s);
                if ($urandom % 6 == 0)
                    b = $urandom_range(len, spg_pkg::PAGE_BYTES - 1);
                else
                    b = $urandom_range(0, len - 1);
                // byte 0 of every claimed tuple is always written
                if (b < len && !byte_set[tuple_off[s] + b])
                    b = 0;
            end else begin
                b = $urandom % spg_pkg::PAGE_BYTES;
            end
            send_item(spg_pkg::FUNC_READ, s, b, $urandom, $urandom);
        end
    endtask

    task automatic noise_item();
        case ($urandom % 3)
            0: send_item(spg_pkg::FUNC_INSERT, $urandom,
                         $urandom_range(1, spg_pkg::PAGE_BYTES - 1), $urandom, $urandom);
            1: send_item(spg_pkg::FUNC_INSERT, $urandom, 0,
                         ($urandom % 3 == 0) ? 0
                                             : $urandom_range(spg_pkg::PAGE_BYTES - 5, 8191),
                         $urandom);
            default: send_item(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    // Receiver stall pattern, with one long hold-off so the block backs up
    initial begin
        int phase;
        int span;
        int mode;
        wait (aresetn);
        for (phase = 0; ; phase++) begin
            if (phase == 6) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                span = $urandom_range(16, 96);
                mode = $urandom % 3;
                repeat (span) begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= $urandom % 2;
                        default: m_tready <= ($urandom % 4 == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        int r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(spg_pkg::FUNC_READ, 0, 0, 0, 0);                        // empty page
        send_item(spg_pkg::FUNC_INSERT, 0, 5, 0, 8'hFF);     // byte with no open insert
        send_item(spg_pkg::FUNC_INSERT, 11'h7FF, 0, 0, 8'h00);         // zero-size tuple
        send_item(spg_pkg::FUNC_INSERT, 0, 0, 13'h1FFF, 8'hFF);
        send_item(spg_pkg::FUNC_INSERT, 0, 0, spg_pkg::PAGE_BYTES - 5, 8'h3C);  // too big
        send_item(spg_pkg::FUNC_INSERT, 0, 0, spg_pkg::PAGE_BYTES - 6, 8'h81);  // exact fit
        send_item(spg_pkg::FUNC_INSERT, 0, spg_pkg::PAGE_BYTES - 7, 0, 8'hFF);
        send_item(spg_pkg::FUNC_INSERT, 0, spg_pkg::PAGE_BYTES - 6, 0, 8'h55);  // past end
        send_item(spg_pkg::FUNC_INSERT, 0, 12'hFFF, 0, 8'h55);
        send_item(spg_pkg::FUNC_READ, 0, 0, 0, 0);
        send_item(spg_pkg::FUNC_READ, 0, spg_pkg::PAGE_BYTES - 7, 0, 0);
        send_item(spg_pkg::FUNC_READ, 0, 12'hFFF, 13'h1FFF, 8'hFF);
        send_item(spg_pkg::FUNC_READ, 11'h7FF, 0, 0, 0);
        send_item(spg_pkg::FUNC_READ, 1, 0, 0, 0);
        send_item(spg_pkg::FUNC_INSERT, 0, 0, 1, 8'h00);                   // page full
        send_item(FUNC_UNUSED, 11'h7FF, 12'hFFF, 13'h1FFF, 8'hFF);
        send_item(spg_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        send_item(spg_pkg::FUNC_INSERT, 0, 0, 3, 8'h00);
        send_item(spg_pkg::FUNC_INSERT, 0, 1, 0, 8'hA5);
        send_item(spg_pkg::FUNC_INSERT, 0, 2, 0, 8'hFF);
        send_item(spg_pkg::FUNC_INSERT, 0, 3, 0, 8'h11);
        send_item(spg_pkg::FUNC_INSERT, 0, 0, 1, 8'h7E);
        send_item(spg_pkg::FUNC_READ, 0, 2, 0, 0);
        send_item(spg_pkg::FUNC_READ, 1, 0, 0, 0);
        send_item(spg_pkg::FUNC_READ, 0, 3, 0, 0);

        while (sent < REQ_TARGET) begin
            r = $urandom % 100;
            if (r < ((room_left < 400) ? 20 : 2))
                send_item(spg_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
            else if (r < 60)
                insert_run();
            else if (r < 90)
                read_run();
            else
                noise_item();
        end
        s_tvalid <= 1'b0;

        // let the scoreboard record the last request before draining
        @(posedge aclk);
        wait (pending == 0);
        repeat (12) @(posedge aclk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/spg_pkg.sv
hdl/spg_ctrl.sv
hdl/spg_datapath.sv
hdl/slotted_page_store.sv
hdl/spg_checker.sv
bench/spg_checker.sv
bench/tb.sv
